FILE: rtl/core/multi_delay_feedback_reverb_top_macros.svh
// Assertion macros for the multi-tap feedback delay reverb.
// Used by rtl/core/multi_delay_feedback_reverb_top.sv; expects i_clk and i_rst_n in scope.
`ifndef MULTI_DELAY_FEEDBACK_REVERB_TOP_MACROS_SVH
`define MULTI_DELAY_FEEDBACK_REVERB_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MDFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MDFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mdfr_pkg.sv
// Shared constants and types for the multi-tap feedback delay reverb.
// No dependencies; imported by multi_delay_feedback_reverb_top.
package mdfr_pkg;

    // Delay store geometry.
    localparam int MAX_LINES  = 4;
    localparam int LINE_DEPTH = 16384;

    localparam int LINE_IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LINE_CNT_W = $clog2(MAX_LINES + 1);
    localparam int POS_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
    localparam int MEM_DEPTH  = MAX_LINES * LINE_DEPTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // Configuration port.
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 5;
    localparam int NUM_LEN_REGS = 4;
    localparam int LEN_CFG_W    = 15;

    // Datapath widths.
    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 16;
    localparam int SUM_W    = SAMPLE_W + ((MAX_LINES > 1) ? $clog2(MAX_LINES) : 0);
    localparam int PROD_W   = SUM_W + GAIN_W + 1;
    localparam int ACC_W    = PROD_W + 1;
    localparam int MAG_W    = ACC_W;
    localparam int HI_W     = MAG_W - GAIN_W;
    localparam int PHI_W    = HI_W + GAIN_W;
    localparam int PLO_W    = 2 * GAIN_W;
    localparam int QS_W     = PHI_W + 1;
    localparam int Y_W      = QS_W + 1;
    localparam int X_SHIFT  = 14;
    localparam int Q_SHIFT  = 14;

    // Sample formats.
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_U8  = 2'd0;
    localparam t_mode MODE_S16 = 2'd1;
    localparam t_mode MODE_S32 = 2'd2;

    // Register map, by word index.
    typedef enum logic [2:0] {
        REG_SAMPLE_MODE  = 3'd0,
        REG_DECAY_GAIN   = 3'd1,
        REG_OUTPUT_SCALE = 3'd2,
        REG_ACTIVE_LINES = 3'd3,
        REG_LINE_LEN_A   = 3'd4,
        REG_LINE_LEN_B   = 3'd5,
        REG_LINE_LEN_C   = 3'd6,
        REG_LINE_LEN_D   = 3'd7
    } t_reg_idx;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_READ  = 9'b000000010,
        ST_SUM   = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_ADD   = 9'b000010000,
        ST_ABS   = 9'b000100000,
        ST_SCALE = 9'b001000000,
        ST_SAT   = 9'b010000000,
        ST_WRITE = 9'b100000000
    } t_state;

endpackage

FILE: rtl/core/multi_delay_feedback_reverb_top.sv
// Multi-tap feedback delay reverb: delay store, sequencer, fixed-point datapath, APB registers.
// Depends on mdfr_pkg and multi_delay_feedback_reverb_top_macros.svh.
//
// Usage
// Samples enter on the s_axis channel: tdata carries the raw sample, tuser the restart flag
// and tlast the end-of-chunk marker. Each sample yields exactly one result on m_axis, with
// tlast copied through. Registers are written over the APB port; the user must keep to
// writing them while the block is idle, which the block does not enforce. With L active
// lines (L = min(active_lines, 4)) an item takes L delay-store reads, the sum step (skipped
// when L is zero), the multiply, add, absolute-value, scale and saturate steps and L
// write-backs. A new sample is taken only once the write-backs are done, since the delay
// store has a single read and a single write port. The output register holds a result
// until it is taken, and the next sample is accepted meanwhile; only if a second result
// is ready before the first is taken does the sequencer wait. Reset loads the default
// registers and empties every line at once: a per-line fill count marks which entries
// have been written since the last reset or restart, and unwritten entries read as zero,
// so no clearing pass is needed. Restart empties the lines likewise, before its sample.
`include "multi_delay_feedback_reverb_top_macros.svh"

module multi_delay_feedback_reverb_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample input: tdata = sample_in[31:0]; tuser = restart; tlast = chunk_last.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mdfr_pkg::SAMPLE_W-1:0]       s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    // Result output: tdata = sample_out[31:0]; tlast = chunk_last_out.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mdfr_pkg::SAMPLE_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tlast,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mdfr_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mdfr_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mdfr_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mdfr_pkg::*;

    localparam logic signed [Y_W-1:0] Y_MIN8  = Y_W'(-128);
    localparam logic signed [Y_W-1:0] Y_MAX8  = Y_W'(127);
    localparam logic signed [Y_W-1:0] Y_MIN16 = Y_W'(-32768);
    localparam logic signed [Y_W-1:0] Y_MAX16 = Y_W'(32767);
    localparam logic signed [Y_W-1:0] Y_MIN32 = Y_W'(signed'(32'h8000_0000));
    localparam logic signed [Y_W-1:0] Y_MAX32 = Y_W'(signed'(32'h7FFF_FFFF));

    // Configuration registers.
    t_mode                  r_mode;
    logic [GAIN_W-1:0]      r_decay;
    logic [GAIN_W-1:0]      r_scale;
    logic [2:0]             r_active;
    logic [LEN_CFG_W-1:0]   r_line_len [NUM_LEN_REGS];

    // Sequencer and line bookkeeping.
    t_state                 r_state;
    t_state                 n_state;
    logic [LINE_IDX_W-1:0]  r_idx;
    logic [POS_W-1:0]       r_pos [MAX_LINES];
    logic [LEN_W-1:0]       r_hw  [MAX_LINES];
    logic                   r_rd_pend;
    logic                   r_rd_ok;

    // Datapath registers.
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_last;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic [MAG_W-1:0]           r_mag;
    logic                       r_neg;
    logic [PHI_W-1:0]           r_phi;
    logic [PLO_W-1:0]           r_plo;
    logic [SAMPLE_W-1:0]        r_y;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;
    logic                       r_out_last;

    // Delay store.
    logic [SAMPLE_W-1:0]    r_delay_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0]    r_mem_q;

    logic                   w_cfg_we;
    t_reg_idx               w_reg_idx;
    logic [LINE_CNT_W-1:0]  w_lines;
    logic                   w_in_acc;
    logic                   w_idx_last;
    logic [POS_W-1:0]       w_cur_pos;
    logic [LEN_W-1:0]       w_cur_hw;
    logic [ADDR_W-1:0]      w_mem_addr;
    logic                   w_mem_re;
    logic                   w_mem_we;
    logic [LEN_CFG_W-1:0]   w_len_cfg;
    logic                   w_len_fixed;
    logic [LEN_W-1:0]       w_cur_len;
    logic [LEN_W-1:0]       w_pos_inc;
    logic signed [SAMPLE_W-1:0] w_x;
    logic [QS_W-1:0]        w_q;
    logic signed [Y_W-1:0]  w_y;
    logic signed [Y_W-1:0]  w_y_sat;
    logic [SAMPLE_W-1:0]    w_out_data;
    logic                   w_sat_done;

    // APB decode; pready is tied high.
    assign pready    = 1'b1;
    assign w_cfg_we  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_S16;
            r_decay       <= GAIN_W'(16384);
            r_scale       <= GAIN_W'(26214);
            r_active      <= 3'd4;
            r_line_len[0] <= LEN_CFG_W'(4096);
            r_line_len[1] <= LEN_CFG_W'(8192);
            r_line_len[2] <= LEN_CFG_W'(12288);
            r_line_len[3] <= LEN_CFG_W'(16384);
        end else if (w_cfg_we) begin
            unique case (w_reg_idx)
                REG_SAMPLE_MODE:  r_mode        <= pwdata[1:0];
                REG_DECAY_GAIN:   r_decay       <= pwdata[GAIN_W-1:0];
                REG_OUTPUT_SCALE: r_scale       <= pwdata[GAIN_W-1:0];
                REG_ACTIVE_LINES: r_active      <= pwdata[2:0];
                REG_LINE_LEN_A:   r_line_len[0] <= pwdata[LEN_CFG_W-1:0];
                REG_LINE_LEN_B:   r_line_len[1] <= pwdata[LEN_CFG_W-1:0];
                REG_LINE_LEN_C:   r_line_len[2] <= pwdata[LEN_CFG_W-1:0];
                REG_LINE_LEN_D:   r_line_len[3] <= pwdata[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_reg_idx)
            REG_SAMPLE_MODE:  prdata = CFG_DATA_W'(r_mode);
            REG_DECAY_GAIN:   prdata = CFG_DATA_W'(r_decay);
            REG_OUTPUT_SCALE: prdata = CFG_DATA_W'(r_scale);
            REG_ACTIVE_LINES: prdata = CFG_DATA_W'(r_active);
            REG_LINE_LEN_A:   prdata = CFG_DATA_W'(r_line_len[0]);
            REG_LINE_LEN_B:   prdata = CFG_DATA_W'(r_line_len[1]);
            REG_LINE_LEN_C:   prdata = CFG_DATA_W'(r_line_len[2]);
            REG_LINE_LEN_D:   prdata = CFG_DATA_W'(r_line_len[3]);
            default:          prdata = '0;
        endcase
    end

    // Number of lines in use, clamped to the lines that exist.
    assign w_lines = (32'(r_active) > MAX_LINES) ? LINE_CNT_W'(MAX_LINES)
                                                 : LINE_CNT_W'(r_active);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_idx_last    = (LINE_CNT_W'(r_idx) + LINE_CNT_W'(1)) == w_lines;

    // Current line: position, fill count and delay-store address.
    assign w_cur_pos  = r_pos[r_idx];
    assign w_cur_hw   = r_hw[r_idx];
    assign w_mem_addr = ADDR_W'(r_idx) * ADDR_W'(LINE_DEPTH) + ADDR_W'(w_cur_pos);
    assign w_mem_re   = (r_state == ST_READ);
    assign w_mem_we   = (r_state == ST_WRITE);

    // Effective length of the current line; lines without a register use the full depth.
    always_comb begin
        w_len_cfg   = '0;
        w_len_fixed = 1'b1;
        for (int k = 0; k < NUM_LEN_REGS; k++) begin
            if (32'(r_idx) == k) begin
                w_len_cfg   = r_line_len[k];
                w_len_fixed = 1'b0;
            end
        end
        if (w_len_fixed || ({17'b0, w_len_cfg} > 32'(LINE_DEPTH))) begin
            w_cur_len = LEN_W'(LINE_DEPTH);
        end else if (w_len_cfg == '0) begin
            w_cur_len = LEN_W'(1);
        end else begin
            w_cur_len = LEN_W'(w_len_cfg);
        end
    end
    assign w_pos_inc = LEN_W'(w_cur_pos) + LEN_W'(1);

    // Input sample to a signed value per format.
    always_comb begin
        case (r_mode)
            MODE_U8:  w_x = SAMPLE_W'(signed'({1'b0, s_axis_tdata[7:0]})) - SAMPLE_W'(128);
            MODE_S16: w_x = SAMPLE_W'(signed'(s_axis_tdata[15:0]));
            default:  w_x = signed'(s_axis_tdata);
        endcase
    end

    // Scaled result, sign restored and saturated to the sample range.
    assign w_q = (QS_W'(r_phi) + QS_W'(r_plo[PLO_W-1:GAIN_W])) >> Q_SHIFT;
    assign w_y = r_neg ? -signed'({1'b0, w_q}) : signed'({1'b0, w_q});

    always_comb begin
        case (r_mode)
            MODE_U8: begin
                w_y_sat    = (w_y < Y_MIN8) ? Y_MIN8 : ((w_y > Y_MAX8) ? Y_MAX8 : w_y);
                w_out_data = {24'b0, ~w_y_sat[7], w_y_sat[6:0]};
            end
            MODE_S16: begin
                w_y_sat    = (w_y < Y_MIN16) ? Y_MIN16 : ((w_y > Y_MAX16) ? Y_MAX16 : w_y);
                w_out_data = {16'b0, w_y_sat[15:0]};
            end
            default: begin
                w_y_sat    = (w_y < Y_MIN32) ? Y_MIN32 : ((w_y > Y_MAX32) ? Y_MAX32 : w_y);
                w_out_data = w_y_sat[SAMPLE_W-1:0];
            end
        endcase
    end

    // The result leaves the saturation step once the output register is free.
    assign w_sat_done = !r_out_valid || m_axis_tready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (w_lines == '0) ? ST_MUL : ST_READ;
                end
            end
            ST_READ: begin
                if (w_idx_last) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = ST_ABS;
            ST_ABS:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_SAT;
            ST_SAT: begin
                if (w_sat_done) begin
                    n_state = (w_lines == '0) ? ST_IDLE : ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (w_idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state: sequencer, line index, positions, fill counts, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_LINES; k++) begin
                r_pos[k] <= '0;
                r_hw[k]  <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_rd_pend <= w_mem_re;
            if (w_in_acc && s_axis_tuser) begin
                for (int k = 0; k < MAX_LINES; k++) begin
                    r_pos[k] <= '0;
                    r_hw[k]  <= '0;
                end
            end
            if (r_state == ST_READ || r_state == ST_WRITE) begin
                r_idx <= w_idx_last ? '0 : r_idx + LINE_IDX_W'(1);
            end
            if (r_state == ST_WRITE) begin
                r_pos[r_idx] <= (w_pos_inc >= w_cur_len) ? '0 : w_pos_inc[POS_W-1:0];
                if (LEN_W'(w_cur_pos) == w_cur_hw) begin
                    r_hw[r_idx] <= w_pos_inc;
                end
            end
            if (r_state == ST_SAT && w_sat_done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic pipeline, one step per sequencer state.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x    <= w_x;
            r_last <= s_axis_tlast;
            r_sum  <= '0;
        end
        if (r_state == ST_READ) begin
            r_rd_ok <= LEN_W'(w_cur_pos) < w_cur_hw;
        end
        if (r_rd_pend && r_rd_ok) begin
            r_sum <= r_sum + SUM_W'(signed'(r_mem_q));
        end
        if (r_state == ST_MUL) begin
            r_prod <= r_sum * signed'({1'b0, r_decay});
        end
        if (r_state == ST_ADD) begin
            r_acc <= ACC_W'(r_prod) + (ACC_W'(r_x) <<< X_SHIFT);
        end
        if (r_state == ST_ABS) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= r_acc[ACC_W-1] ? MAG_W'(-r_acc) : MAG_W'(r_acc);
        end
        if (r_state == ST_SCALE) begin
            r_phi <= PHI_W'(r_mag[MAG_W-1:GAIN_W]) * PHI_W'(r_scale);
            r_plo <= PLO_W'(r_mag[GAIN_W-1:0]) * PLO_W'(r_scale);
        end
        if (r_state == ST_SAT && w_sat_done) begin
            r_y        <= w_y_sat[SAMPLE_W-1:0];
            r_out_data <= w_out_data;
            r_out_last <= r_last;
        end
    end

    // Delay store: one read and one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_delay_mem[w_mem_addr] <= r_y;
        end
        if (w_mem_re) begin
            r_mem_q <= r_delay_mem[w_mem_addr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // A position never runs ahead of the entries written since the last clear.
    `MDFR_ASSERT_NOW(a_pos_within_fill, (r_state == ST_WRITE || r_state == ST_READ),
        (LEN_W'(w_cur_pos) <= w_cur_hw), "line position beyond its fill count")
    // Fill count never exceeds the line depth.
    `MDFR_ASSERT_NOW(a_fill_bounded, (r_state == ST_WRITE),
        (w_cur_hw <= LEN_W'(LINE_DEPTH)), "fill count beyond line depth")
    // Restart empties the lines before the first read; line 0 is the one checked.
    `MDFR_ASSERT_NEXT(a_restart_clears, (w_in_acc && s_axis_tuser),
        (r_pos[0] == '0 && r_hw[0] == '0), "restart left line state behind")
    // A finished result is always presented on the output.
    `MDFR_ASSERT_NEXT(a_result_shown, (r_state == ST_SAT && w_sat_done),
        (r_out_valid && r_state != ST_SAT), "result lost at output register")

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the multi-tap feedback delay reverb top level.
// Depends on mdfr_pkg and on the RTL of multi_delay_feedback_reverb_top; needs no files.
// A built-in predictor works out each result and a monitor compares every output transaction.
module tb;
    import mdfr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int IDLE_PERCENT  = 38;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 72;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
        logic                last;
    } t_audio_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_audio_out;

    // Clock, reset and block ports.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the registers and of the echo memory.
    logic [1:0]            cfg_mode;
    logic [15:0]           cfg_decay;
    logic [15:0]           cfg_scale;
    logic [2:0]            cfg_lines;
    logic [14:0]           cfg_len [0:3];
    logic signed [31:0]    echo_mem [0:MEM_DEPTH-1];
    int unsigned           tap_pos [0:MAX_LINES-1];

    t_audio_in             pending_samples [$];
    t_audio_out            expected_out [$];

    bit                    calm = 1'b0;
    int                    err_count = 0;
    int                    samples_taken = 0;
    int                    results_checked = 0;
    int                    restarts_taken = 0;
    int                    settings_used = 0;
    int                    cycle_count = 0;

    multi_delay_feedback_reverb_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with a period of two time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Empties every delay line and rewinds every position.
    function automatic void clear_echoes();
        for (int k = 0; k < MEM_DEPTH; k++) begin
            echo_mem[k] = '0;
        end
        for (int k = 0; k < MAX_LINES; k++) begin
            tap_pos[k] = 0;
        end
    endfunction

    // Works out the output for one accepted sample and updates the echo state.
    function automatic t_audio_out predict_reverb(input t_audio_in smp);
        longint          x;
        longint          tap_sum;
        longint          acc;
        longint          y;
        longint          lo_lim;
        longint          hi_lim;
        longint unsigned mag;
        longint unsigned q;
        int unsigned     n_lines;
        int unsigned     len;
        int unsigned     p;
        t_audio_out      res;
        if (smp.restart) begin
            clear_echoes();
        end
        // Convert the raw bits to a signed value.
        if (cfg_mode == MODE_U8) begin
            x = longint'(smp.sample[7:0]) - 128;
            lo_lim = -128;
            hi_lim = 127;
        end else if (cfg_mode == MODE_S16) begin
            x = longint'($signed(smp.sample[15:0]));
            lo_lim = -32768;
            hi_lim = 32767;
        end else begin
            x = longint'($signed(smp.sample));
            lo_lim = -64'sd2147483648;
            hi_lim = 64'sd2147483647;
        end
        n_lines = (cfg_lines > MAX_LINES) ? MAX_LINES : cfg_lines;
        tap_sum = 0;
        for (int unsigned i = 0; i < n_lines; i++) begin
            tap_sum += echo_mem[i * LINE_DEPTH + tap_pos[i]];
        end
        // Q.14 accumulate, then scale the magnitude in two halves to stay within 64 bits.
        acc = x * 16384 + tap_sum * longint'(cfg_decay);
        mag = (acc < 0) ? longint'(-acc) : acc;
        q = (((mag >> 16) * cfg_scale) + (((mag & 64'hFFFF) * cfg_scale) >> 16)) >> 14;
        y = (acc < 0) ? -longint'(q) : longint'(q);
        if (y < lo_lim) y = lo_lim;
        if (y > hi_lim) y = hi_lim;
        if (cfg_mode == MODE_U8) begin
            res.sample = 32'(y + 128);
        end else if (cfg_mode == MODE_S16) begin
            res.sample = {16'h0000, y[15:0]};
        end else begin
            res.sample = y[31:0];
        end
        res.last = smp.last;
        // Write the saturated value back and advance each active line.
        for (int unsigned i = 0; i < n_lines; i++) begin
            p = tap_pos[i];
            len = cfg_len[i];
            if (len == 0) len = 1;
            if (len > LINE_DEPTH) len = LINE_DEPTH;
            echo_mem[i * LINE_DEPTH + p] = y[31:0];
            tap_pos[i] = (p + 1 >= len) ? 0 : p + 1;
        end
        return res;
    endfunction

    // Writes one register, updates the shadow copy and reads the value back.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] rd_want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SAMPLE_MODE: begin
                cfg_mode = val[1:0];
                rd_want = {30'b0, val[1:0]};
            end
            REG_DECAY_GAIN: begin
                cfg_decay = val[15:0];
                rd_want = {16'b0, val[15:0]};
            end
            REG_OUTPUT_SCALE: begin
                cfg_scale = val[15:0];
                rd_want = {16'b0, val[15:0]};
            end
            REG_ACTIVE_LINES: begin
                cfg_lines = val[2:0];
                rd_want = {29'b0, val[2:0]};
            end
            default: begin
                cfg_len[idx - REG_LINE_LEN_A] = val[14:0];
                rd_want = {17'b0, val[14:0]};
            end
        endcase
        // Read back in a separate transaction.
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== rd_want) begin
            $error("register %s: expected %0h, actual %0h", idx.name(), rd_want, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [15:0] decay,
                              input logic [15:0] scale, input logic [2:0] lines,
                              input logic [14:0] la, input logic [14:0] lb,
                              input logic [14:0] lc, input logic [14:0] ld);
        write_reg(REG_SAMPLE_MODE, {30'b0, mode});
        write_reg(REG_DECAY_GAIN, {16'b0, decay});
        write_reg(REG_OUTPUT_SCALE, {16'b0, scale});
        write_reg(REG_ACTIVE_LINES, {29'b0, lines});
        write_reg(REG_LINE_LEN_A, {17'b0, la});
        write_reg(REG_LINE_LEN_B, {17'b0, lb});
        write_reg(REG_LINE_LEN_C, {17'b0, lc});
        write_reg(REG_LINE_LEN_D, {17'b0, ld});
        settings_used++;
    endtask

    // Waits until the block has taken and returned everything, then lets it settle.
    task automatic drain();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_out.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_sample(input logic [31:0] smp, input logic rst, input logic lst);
        t_audio_in it;
        it.sample  = smp;
        it.restart = rst;
        it.last    = lst;
        pending_samples.push_back(it);
    endtask

    // Short lines most of the time so that echoes come back within a phase.
    function automatic logic [14:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return 15'($urandom_range(1, 40));
        if (r < 80) return 15'd0;
        if (r < 85) return 15'd16384;
        if (r < 90) return 15'($urandom_range(16385, 32767));
        return 15'($urandom_range(1, 16384));
    endfunction

    function automatic logic [15:0] pick_gain();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'hFFFF;
        return 16'($urandom_range(0, 32767));
    endfunction

    function automatic logic [31:0] pick_sample();
        logic [31:0] corners [10];
        corners = '{32'h0, 32'h7F, 32'h80, 32'hFF, 32'h7FFF, 32'h8000, 32'hFFFF,
                    32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
        if ($urandom_range(0, 99) < 10) return corners[$urandom_range(0, 9)];
        return $urandom();
    endfunction

    // Sample driver: presents the next queued sample once the previous one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_samples.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_samples[0].sample;
                s_axis_tuser  <= pending_samples[0].restart;
                s_axis_tlast  <= pending_samples[0].last;
                void'(pending_samples.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Monitor: predicts on each input transaction and checks each output transaction.
    always @(posedge i_clk) begin : monitor_p
        t_audio_in  got_in;
        t_audio_out want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                got_in.sample  = s_axis_tdata;
                got_in.restart = s_axis_tuser;
                got_in.last    = s_axis_tlast;
                expected_out.push_back(predict_reverb(got_in));
                samples_taken++;
                if (got_in.restart) restarts_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_out.size() == 0) begin
                    $error("sample_out: no result expected, actual %0h", m_axis_tdata);
                    err_count++;
                end else begin
                    want = expected_out.pop_front();
                    results_checked++;
                    if (m_axis_tdata !== want.sample) begin
                        $error("sample_out: expected %0h, actual %0h", want.sample, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("chunk_last_out: expected %0b, actual %0b", want.last,
                               m_axis_tlast);
                        err_count++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout with %0d results outstanding", expected_out.size());
            $display("[multi_delay_feedback_reverb_top] ERROR");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin : stimulus_p
        logic [1:0]  mode;
        logic [2:0]  lines;
        logic [15:0] decay;
        logic [15:0] scale;
        int unsigned eff;
        cfg_mode  = MODE_S16;
        cfg_decay = 16'd16384;
        cfg_scale = 16'd26214;
        cfg_lines = 3'd4;
        cfg_len   = '{15'd4096, 15'd8192, 15'd12288, 15'd16384};
        clear_echoes();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 16-bit corners, junk upper bits, a restart, chunk ends.
        add_sample(32'h0000_0000, 1'b0, 1'b0);
        add_sample(32'h0000_7FFF, 1'b0, 1'b0);
        add_sample(32'h0000_8000, 1'b0, 1'b0);
        add_sample(32'h0000_FFFF, 1'b0, 1'b1);
        add_sample(32'hFFFF_0001, 1'b0, 1'b0);
        add_sample(32'h1234_5678, 1'b1, 1'b0);
        add_sample(32'h0000_0000, 1'b0, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
        drain();

        // 8-bit mode with full gains and tiny lines, one of them zero length.
        set_config(MODE_U8, 16'hFFFF, 16'hFFFF, 3'd4, 15'd1, 15'd2, 15'd3, 15'd0);
        add_sample(32'h0000_0000, 1'b0, 1'b0);
        add_sample(32'h0000_00FF, 1'b0, 1'b0);
        add_sample(32'h0000_0080, 1'b0, 1'b1);
        add_sample(32'h0000_007F, 1'b0, 1'b0);
        add_sample(32'hFFFF_FF00, 1'b0, 1'b0);
        add_sample(32'h0000_00FF, 1'b0, 1'b0);
        add_sample(32'h0000_0080, 1'b1, 1'b0);
        add_sample(32'h0000_0001, 1'b0, 1'b1);
        drain();

        // Mode three, too many lines and an oversized line length.
        set_config(2'd3, 16'hFFFF, 16'hFFFF, 3'd7, 15'd16384, 15'd32767, 15'd5, 15'd1);
        add_sample(32'h8000_0000, 1'b0, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
        add_sample(32'h0000_0000, 1'b0, 1'b1);
        add_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        add_sample(32'h8000_0000, 1'b1, 1'b0);
        add_sample(32'h0000_0001, 1'b0, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0, 1'b1);
        drain();

        // Random phases; positions carry over, so shortened lines occur between phases.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode  = 2'($urandom_range(0, 3));
            lines = 3'($urandom_range(0, 7));
            decay = pick_gain();
            if (ph == 1) begin
                lines = 3'd0;
                decay = 16'h0000;
            end
            eff = (lines > MAX_LINES) ? MAX_LINES : lines;
            // Half the time the normalising gain for these lines and decay, else any value.
            if ($urandom_range(0, 1) == 0) begin
                scale = 16'($urandom());
            end else begin
                scale = ((64'd65536 * 16384) / (16384 + eff * decay) > 65535) ? 16'hFFFF :
                        16'((64'd65536 * 16384) / (16384 + eff * decay));
            end
            if (ph == 2) scale = 16'h0000;
            calm = (ph == 4);
            set_config(mode, decay, scale, lines, pick_len(), pick_len(), pick_len(),
                       pick_len());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                add_sample(pick_sample(), ($urandom_range(0, 99) < 3),
                           ($urandom_range(0, 99) < 12));
            end
            drain();
        end
        calm = 1'b0;

        $display("Run covered %0d samples (%0d with restart) under %0d register settings,",
                 samples_taken, restarts_taken, settings_used + 1);
        $display("with %0d results checked against the predictor.", results_checked);
        if (err_count == 0) begin
            $display("[multi_delay_feedback_reverb_top] OK");
        end else begin
            $display("[multi_delay_feedback_reverb_top] ERROR");
        end
        $finish;
    end

endmodule
